[design/brc_pkg.sv]
package brc_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] CFG_BASE_INTENSITY = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_ALPHA_LEVEL = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LIT_COLOR = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PIXEL_AREA_COLOR = 3'd3;

	localparam logic [8:0] LEVEL_FULL = 9'd256;
	localparam logic [8:0] BASE_RESET = 9'd64;
	localparam logic [8:0] ALPHA_RESET = 9'd128;

	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic [2:0] sector;
		logic       neg;
		logic       grey;
		logic       lvl_zero;
	} hue_tag_t;

	typedef struct packed {
		logic [5:0][8:0] sums;
		logic            big_lit;
		logic            big_pix;
		rgb_t            panel;
	} clip_tag_t;

endpackage

[design/brc_div.sv]
module brc_div
	import brc_pkg::*;
#(
	parameter int LANES = 1,
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int TW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [LANES-1:0][NW-1:0]   num,
	input  logic [LANES-1:0][DW-1:0]   den,
	input  logic [TW-1:0]              tag_in,
	output logic                       out_vld,
	output logic [LANES-1:0][NW-1:0]   quo,
	output logic [TW-1:0]              tag_out
);

	logic [LANES-1:0][NW-1:0] rem_s [NW];
	logic [LANES-1:0][NW-1:0] quo_s [NW+1];
	logic [LANES-1:0][DW-1:0] den_s [NW];
	logic [TW-1:0]            tag_s [NW+1];
	logic [NW:0]              vld_s;

	logic [LANES-1:0][NW+DW-1:0] dsh [NW];
	logic [LANES-1:0][NW-1:0]    rem_nx [NW];
	logic [LANES-1:0][NW-1:0]    quo_nx [NW];

	always_comb begin
		for (int k = 0; k < NW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				dsh[k][l] = {{NW{1'b0}}, den_s[k][l]} << (NW - 1 - k);
				if ({{DW{1'b0}}, rem_s[k][l]} >= dsh[k][l]) begin
					rem_nx[k][l] = rem_s[k][l] - dsh[k][l][NW-1:0];
					quo_nx[k][l] = quo_s[k][l] | (NW'(1) << (NW - 1 - k));
				end else begin
					rem_nx[k][l] = rem_s[k][l];
					quo_nx[k][l] = quo_s[k][l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NW-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			den_s[0] <= den;
			tag_s[0] <= tag_in;
			for (int k = 0; k < NW - 1; k++) begin
				rem_s[k+1] <= rem_nx[k];
				den_s[k+1] <= den_s[k];
			end
			for (int k = 0; k < NW; k++) begin
				quo_s[k+1] <= quo_nx[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[NW];
	assign quo = quo_s[NW];
	assign tag_out = tag_s[NW];

endmodule

[design/brc_rebuild.sv]
module brc_rebuild
	import brc_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [FRAC_BITS+2:0] hq,
	input  logic [FRAC_BITS:0]   sq,
	input  logic [FRAC_BITS:0]   vq,
	output logic                 out_vld,
	output rgb_t                 col
);

	localparam int F = FRAC_BITS;
	localparam logic [F:0] One = {1'b1, {F{1'b0}}};

	logic [2:0]   sec_s1, sec_s2;
	logic [F:0]   vq_s1, vq_s2, p_s1, p_s2, sf_s1, st_s1, q_s2, t_s2;
	logic [2:0]   vld_s;
	rgb_t         col_s3;

	logic [F-1:0]   ff;
	logic [F:0]     inv_ff;
	logic [2*F+1:0] p_full, sf_full, st_full, q_full, t_full;
	logic [F:0]     sel [3];
	logic [F+8:0]   byte_full [3];

	always_comb begin
		ff = hq[F-1:0];
		inv_ff = One - {1'b0, ff};
		p_full = (2*F+2)'(vq) * (2*F+2)'(One - sq);
		sf_full = (2*F+2)'(sq) * (2*F+2)'(ff);
		st_full = (2*F+2)'(sq) * (2*F+2)'(inv_ff);
		q_full = (2*F+2)'(vq_s1) * (2*F+2)'(One - sf_s1);
		t_full = (2*F+2)'(vq_s1) * (2*F+2)'(One - st_s1);
		case (sec_s2)
			3'd0: begin sel[0] = vq_s2; sel[1] = t_s2; sel[2] = p_s2; end
			3'd1: begin sel[0] = q_s2; sel[1] = vq_s2; sel[2] = p_s2; end
			3'd2: begin sel[0] = p_s2; sel[1] = vq_s2; sel[2] = t_s2; end
			3'd3: begin sel[0] = p_s2; sel[1] = q_s2; sel[2] = vq_s2; end
			3'd4: begin sel[0] = t_s2; sel[1] = p_s2; sel[2] = vq_s2; end
			default: begin sel[0] = vq_s2; sel[1] = p_s2; sel[2] = q_s2; end
		endcase
		for (int k = 0; k < 3; k++) begin
			byte_full[k] = ({8'd0, sel[k]} * (F+9)'(255)) >> F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1 <= hq[F+2:F];
			vq_s1 <= vq;
			p_s1 <= p_full[2*F:F];
			sf_s1 <= sf_full[2*F:F];
			st_s1 <= st_full[2*F:F];
			sec_s2 <= sec_s1;
			vq_s2 <= vq_s1;
			p_s2 <= p_s1;
			q_s2 <= q_full[2*F:F];
			t_s2 <= t_full[2*F:F];
			for (int k = 0; k < 3; k++) begin
				col_s3[k] <= (byte_full[k] > (F+9)'(255)) ? 8'd255 : byte_full[k][7:0];
			end
		end
	end

	assign out_vld = vld_s[2];
	assign col = col_s3;

endmodule

[design/brc_blend.sv]
module brc_blend
	import brc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  rgb_t        col,
	input  logic [8:0]  alpha,
	input  logic [23:0] lit,
	input  logic [23:0] pix,
	output logic        out_vld,
	output rgb_t        panel,
	output rgb_t        lit_out,
	output rgb_t        pix_out
);

	logic       vld_s1, vld_s2;
	rgb_t       col_s1, col_s2, sc_s1;
	logic [5:0][8:0] sums_s2;

	logic [16:0] sc_full [3];
	logic [8:0]  m_lit, m_pix;
	logic [5:0][16:0] num;
	logic [5:0][8:0]  den;
	clip_tag_t tag_in, tag_out;
	logic        dv_vld;
	logic [5:0][16:0] quo;

	logic        out_vld_q;
	rgb_t        panel_q, lit_q, pix_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sc_full[k] = {9'd0, col[k]} * {8'd0, LEVEL_FULL - alpha};
		end
		m_lit = (sums_s2[0] > sums_s2[1]) ? sums_s2[0] : sums_s2[1];
		m_lit = (m_lit > sums_s2[2]) ? m_lit : sums_s2[2];
		m_pix = (sums_s2[3] > sums_s2[4]) ? sums_s2[3] : sums_s2[4];
		m_pix = (m_pix > sums_s2[5]) ? m_pix : sums_s2[5];
		for (int j = 0; j < 6; j++) begin
			num[j] = ({8'd0, sums_s2[j]} << 8) - {8'd0, sums_s2[j]};
			den[j] = (j < 3) ? m_lit : m_pix;
		end
		tag_in.sums = sums_s2;
		tag_in.big_lit = m_lit > 9'd255;
		tag_in.big_pix = m_pix > 9'd255;
		tag_in.panel = col_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= col;
			for (int k = 0; k < 3; k++) begin
				sc_s1[k] <= sc_full[k][15:8];
			end
			col_s2 <= col_s1;
			for (int k = 0; k < 3; k++) begin
				sums_s2[k] <= {1'b0, sc_s1[k]} + {1'b0, lit[23-8*k -: 8]};
				sums_s2[k+3] <= {1'b0, sc_s1[k]} + {1'b0, pix[23-8*k -: 8]};
			end
			panel_q <= tag_out.panel;
			for (int k = 0; k < 3; k++) begin
				lit_q[k] <= tag_out.big_lit ? quo[k][7:0] : tag_out.sums[k][7:0];
				pix_q[k] <= tag_out.big_pix ? quo[k+3][7:0] : tag_out.sums[k+3][7:0];
			end
		end
	end

	brc_div #(
		.LANES(6),
		.NW(17),
		.DW(9),
		.TW($bits(clip_tag_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s2),
		.num(num),
		.den(den),
		.tag_in(tag_in),
		.out_vld(dv_vld),
		.quo(quo),
		.tag_out(tag_out)
	);

	assign out_vld = out_vld_q;
	assign panel = panel_q;
	assign lit_out = lit_q;
	assign pix_out = pix_q;

endmodule

[design/backlight_color_remap_unit.sv]
// Backlight color remapper. Each request carries an RGB color and a backlight level and yields
// one result holding the panel color and the lit-area and pixel-area blends. A request can be
// taken in every cycle while in_stall is low. Each result passes through two bit-per-stage
// division pipelines: one of FRAC_BITS + 11 stages for hue, saturation and value, and one
// of 17 stages for the clip. The whole pipeline holds while a finished result is stalled.
// Registers may be written only while no request is in flight.
module backlight_color_remap_unit
	import brc_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          base_red,
	input  logic [7:0]          base_green,
	input  logic [7:0]          base_blue,
	input  logic [7:0]          backlight_level,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          panel_red,
	output logic [7:0]          panel_green,
	output logic [7:0]          panel_blue,
	output logic [7:0]          lit_red,
	output logic [7:0]          lit_green,
	output logic [7:0]          lit_blue,
	output logic [7:0]          pixel_red,
	output logic [7:0]          pixel_green,
	output logic [7:0]          pixel_blue,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int F = FRAC_BITS;
	localparam int NWF = F + 11;
	localparam logic [F:0] One = {1'b1, {F{1'b0}}};
	localparam logic [F+2:0] SixSectors = {3'd6, {F{1'b0}}};

	logic [8:0]  base_q, alpha_q;
	logic [23:0] lit_q, pix_q;

	logic        en;
	logic        vld_s1, vld_s2;
	logic [7:0]  r_s1, g_s1, b_s1, lvl_s1;
	logic [F+2:0] hq_s2;
	logic [F:0]  sq_s2, vq_s2;

	logic [7:0]  mx, mn, diff, adiff;
	logic [9:0]  sum;
	logic [8:0]  bi, al;
	logic [F:0]  baseq, inv_base;
	hue_tag_t    htag_in, htag_out;
	logic [2:0][NWF-1:0] num;
	logic [2:0][9:0]     den;
	logic [2:0][NWF-1:0] quo;
	logic        dv_vld;
	logic [F+2:0] hq_full, frac_ext;
	logic [NWF:0] v_full;

	logic        rb_vld;
	rgb_t        rb_col, panel, lit_o, pix_o;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			alpha_q <= ALPHA_RESET;
			lit_q <= '0;
			pix_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_INTENSITY: base_q <= cfg_data[8:0];
				CFG_ALPHA_LEVEL: alpha_q <= cfg_data[8:0];
				CFG_LIT_COLOR: lit_q <= cfg_data[23:0];
				CFG_PIXEL_AREA_COLOR: pix_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bi = (base_q > LEVEL_FULL) ? LEVEL_FULL : base_q;
		al = (alpha_q > LEVEL_FULL) ? LEVEL_FULL : alpha_q;
		baseq = (F+1)'(bi) << (F - 8);
		inv_base = One - baseq;

		mx = (r_s1 > g_s1) ? r_s1 : g_s1;
		mx = (mx > b_s1) ? mx : b_s1;
		mn = (r_s1 < g_s1) ? r_s1 : g_s1;
		mn = (mn < b_s1) ? mn : b_s1;
		diff = mx - mn;
		sum = {2'd0, r_s1} + {2'd0, g_s1} + {2'd0, b_s1};

		if (mx == r_s1) begin
			htag_in.sector = (g_s1 >= b_s1) ? 3'd0 : 3'd6;
			htag_in.neg = g_s1 < b_s1;
			adiff = (g_s1 >= b_s1) ? g_s1 - b_s1 : b_s1 - g_s1;
		end else if (mx == g_s1) begin
			htag_in.sector = 3'd2;
			htag_in.neg = b_s1 < r_s1;
			adiff = (b_s1 >= r_s1) ? b_s1 - r_s1 : r_s1 - b_s1;
		end else begin
			htag_in.sector = 3'd4;
			htag_in.neg = r_s1 < g_s1;
			adiff = (r_s1 >= g_s1) ? r_s1 - g_s1 : g_s1 - r_s1;
		end
		htag_in.grey = diff == 8'd0;
		htag_in.lvl_zero = lvl_s1 == 8'd0;

		num[0] = NWF'(adiff) << F;
		den[0] = {2'd0, diff};
		num[1] = NWF'(mn) << F;
		den[1] = sum;
		num[2] = NWF'(sum) * NWF'(inv_base);
		den[2] = {2'd0, lvl_s1};

		frac_ext = {2'd0, quo[0][F:0]};
		if (htag_out.neg) begin
			hq_full = {htag_out.sector, {F{1'b0}}} - frac_ext;
		end else begin
			hq_full = {htag_out.sector, {F{1'b0}}} + frac_ext;
		end
		if (hq_full >= SixSectors || htag_out.grey) begin
			hq_full = '0;
		end
		v_full = {1'b0, quo[2]} + (NWF+1)'(baseq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= base_red;
			g_s1 <= base_green;
			b_s1 <= base_blue;
			lvl_s1 <= backlight_level;
			hq_s2 <= hq_full;
			sq_s2 <= htag_out.grey ? '0 : One - quo[1][F:0];
			if (htag_out.lvl_zero || v_full > (NWF+1)'(One)) begin
				vq_s2 <= One;
			end else begin
				vq_s2 <= v_full[F:0];
			end
		end
	end

	brc_div #(
		.LANES(3),
		.NW(NWF),
		.DW(10),
		.TW($bits(hue_tag_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s1),
		.num(num),
		.den(den),
		.tag_in(htag_in),
		.out_vld(dv_vld),
		.quo(quo),
		.tag_out(htag_out)
	);

	brc_rebuild #(
		.FRAC_BITS(F)
	) u_rebuild (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s2),
		.hq(hq_s2),
		.sq(sq_s2),
		.vq(vq_s2),
		.out_vld(rb_vld),
		.col(rb_col)
	);

	brc_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(rb_vld),
		.col(rb_col),
		.alpha(al),
		.lit(lit_q),
		.pix(pix_q),
		.out_vld(out_valid),
		.panel(panel),
		.lit_out(lit_o),
		.pix_out(pix_o)
	);

	assign panel_red = panel[0];
	assign panel_green = panel[1];
	assign panel_blue = panel[2];
	assign lit_red = lit_o[0];
	assign lit_green = lit_o[1];
	assign lit_blue = lit_o[2];
	assign pixel_red = pix_o[0];
	assign pixel_green = pix_o[1];
	assign pixel_blue = pix_o[2];

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a held result");

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(panel_red) && $stable(lit_red)
			&& $stable(pixel_red)))
		else $error("held result changed");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
	import brc_pkg::*;

	typedef struct packed {
		logic [7:0] r, g, b, lvl;
	} color_req_t;

	typedef struct {
		logic [7:0] pr, pg, pb, lr, lg, lb, xr, xg, xb;
		bit         known;
	} remap_t;

	// A directed row: a request and, where it is obvious, its full expected result.
	typedef struct {
		color_req_t req;
		bit         typed;
		logic [7:0] pr, pg, pb, lr, lg, lb, xr, xg, xb;
	} row_t;

	localparam int FB = 12;
	localparam longint ONE = 64'd1 << FB;
	localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] base_red = '0, base_green = '0, base_blue = '0, backlight_level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] panel_red, panel_green, panel_blue;
	logic [7:0] lit_red, lit_green, lit_blue;
	logic [7:0] pixel_red, pixel_green, pixel_blue;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	longint base_lvl = 64, alpha_lvl = 128, lit_rgb = 0, pix_rgb = 0;
	remap_t pending_colors[$];
	int errors = 0;
	bit sending_done = 0;
	bit drain_mode = 0;

	backlight_color_remap_unit dut (.*);

	always #10 clk = ~clk;

	function automatic longint frac_of(longint pos, longint neg, longint d, longint bv);
		if (pos >= neg)
			return bv + ((pos - neg) * ONE) / d;
		return bv - ((neg - pos) * ONE) / d;
	endfunction

	function automatic longint to_byte(longint x);
		longint c;
		c = (x * 255) >> FB;
		return c > 255 ? 255 : c;
	endfunction

	function automatic void blend(longint a[3], longint packed_rgb, output logic [7:0] o[3]);
		longint s[3];
		longint m;
		s[0] = a[0] + ((packed_rgb >> 16) & 255);
		s[1] = a[1] + ((packed_rgb >> 8) & 255);
		s[2] = a[2] + (packed_rgb & 255);
		m = s[0] > s[1] ? s[0] : s[1];
		m = m > s[2] ? m : s[2];
		for (int k = 0; k < 3; k++) begin
			if (m > 255)
				s[k] = (s[k] * 255) / m;
			o[k] = s[k][7:0];
		end
	endfunction

	function automatic remap_t remap_color(color_req_t rq);
		longint r, g, b, l, mx, mn, d, sm, hq, sq, vq, bq, bi, al, sec, ff, p, q, t;
		longint cq[3], col[3], sc[3];
		logic [7:0] lo[3], xo[3];
		remap_t res;
		r = rq.r; g = rq.g; b = rq.b; l = rq.lvl;
		hq = 0; sq = 0;
		mx = r > g ? r : g; mx = mx > b ? mx : b;
		mn = r < g ? r : g; mn = mn < b ? mn : b;
		d = mx - mn;
		sm = r + g + b;
		if (d != 0) begin
			if (mx == r)
				hq = (g >= b) ? frac_of(g, b, d, 0) : 6 * ONE - ((b - g) * ONE) / d;
			else if (mx == g)
				hq = frac_of(b, r, d, 2 * ONE);
			else
				hq = frac_of(r, g, d, 4 * ONE);
			if (hq >= 6 * ONE)
				hq = 0;
			sq = ONE - (mn * ONE) / sm;
		end
		bi = base_lvl > 256 ? 256 : base_lvl;
		bq = bi << (FB - 8);
		if (l == 0) begin
			vq = ONE;
		end else begin
			vq = bq + (sm * (ONE - bq)) / l;
			if (vq > ONE)
				vq = ONE;
		end
		sec = hq >> FB;
		ff = hq & (ONE - 1);
		p = (vq * (ONE - sq)) >> FB;
		q = (vq * (ONE - ((sq * ff) >> FB))) >> FB;
		t = (vq * (ONE - ((sq * (ONE - ff)) >> FB))) >> FB;
		case (sec)
			0: cq = '{vq, t, p};
			1: cq = '{q, vq, p};
			2: cq = '{p, vq, t};
			3: cq = '{p, q, vq};
			4: cq = '{t, p, vq};
			default: cq = '{vq, p, q};
		endcase
		al = alpha_lvl > 256 ? 256 : alpha_lvl;
		for (int k = 0; k < 3; k++) begin
			col[k] = to_byte(cq[k]);
			sc[k] = (col[k] * (256 - al)) >> 8;
		end
		blend(sc, lit_rgb, lo);
		blend(sc, pix_rgb, xo);
		res.pr = 8'(col[0]); res.pg = 8'(col[1]); res.pb = 8'(col[2]);
		res.lr = lo[0]; res.lg = lo[1]; res.lb = lo[2];
		res.xr = xo[0]; res.xg = xo[1]; res.xb = xo[2];
		res.known = 1;
		return res;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BASE_INTENSITY: base_lvl = val & 9'h1FF;
			CFG_ALPHA_LEVEL: alpha_lvl = val & 9'h1FF;
			CFG_LIT_COLOR: lit_rgb = val;
			CFG_PIXEL_AREA_COLOR: pix_rgb = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_colors.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(color_req_t rq, remap_t want);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		base_red <= rq.r;
		base_green <= rq.g;
		base_blue <= rq.b;
		backlight_level <= rq.lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_colors.push_back(want);
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		color_req_t rq;
		for (int i = 0; i < n; i++) begin
			rq = $urandom;
			case ($urandom_range(0, 5))
				0: rq.lvl = 0;
				1: begin
					rq.g = rq.r;
					rq.b = rq.r;
				end
				2: rq.lvl = $urandom_range(0, 1) ? 8'hFF : 8'd1;
				default: ;
			endcase
			send_request(rq, remap_color(rq));
		end
		in_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (drain_mode)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 4)
			out_stall <= 1'b1;
		else if ($urandom_range(0, 99) < 40)
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		remap_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = pending_colors.pop_front();
				if (panel_red !== e.pr) begin $error("panel_red exp %0d got %0d", e.pr, panel_red); errors++; end
				if (panel_green !== e.pg) begin $error("panel_green exp %0d got %0d", e.pg, panel_green); errors++; end
				if (panel_blue !== e.pb) begin $error("panel_blue exp %0d got %0d", e.pb, panel_blue); errors++; end
				if (lit_red !== e.lr) begin $error("lit_red exp %0d got %0d", e.lr, lit_red); errors++; end
				if (lit_green !== e.lg) begin $error("lit_green exp %0d got %0d", e.lg, lit_green); errors++; end
				if (lit_blue !== e.lb) begin $error("lit_blue exp %0d got %0d", e.lb, lit_blue); errors++; end
				if (pixel_red !== e.xr) begin $error("pixel_red exp %0d got %0d", e.xr, pixel_red); errors++; end
				if (pixel_green !== e.xg) begin $error("pixel_green exp %0d got %0d", e.xg, pixel_green); errors++; end
				if (pixel_blue !== e.xb) begin $error("pixel_blue exp %0d got %0d", e.xb, pixel_blue); errors++; end
			end
		end
	end

	initial begin
		row_t rows[$];
		remap_t want;
		rows = '{
			'{'{8'd0, 8'd0, 8'd0, 8'd0}, 1, 255, 255, 255, 127, 127, 127, 127, 127, 127},
			'{'{8'd255, 8'd255, 8'd255, 8'd255}, 1, 255, 255, 255, 127, 127, 127, 127, 127, 127},
			'{'{8'd255, 8'd0, 8'd0, 8'd0}, 1, 255, 0, 0, 127, 0, 0, 127, 0, 0},
			'{'{8'd0, 8'd255, 8'd0, 8'd0}, 1, 0, 255, 0, 0, 127, 0, 0, 127, 0},
			'{'{8'd0, 8'd0, 8'd255, 8'd0}, 1, 0, 0, 255, 0, 0, 127, 0, 0, 127},
			'{'{8'd0, 8'd0, 8'd0, 8'd255}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd255, 8'd200, 8'd10, 8'd100}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd255, 8'd10, 8'd200, 8'd100}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd255, 8'd0, 8'd1, 8'd3}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd10, 8'd200, 8'd120, 8'd50}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd120, 8'd200, 8'd10, 8'd50}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd10, 8'd120, 8'd200, 8'd1}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd120, 8'd10, 8'd200, 8'd7}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd1, 8'd0, 8'd0, 8'd128}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd128, 8'd128, 8'd128, 8'd64}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{'{8'd170, 8'd85, 8'd85, 8'd200}, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
		};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				want.pr = rows[i].pr; want.pg = rows[i].pg; want.pb = rows[i].pb;
				want.lr = rows[i].lr; want.lg = rows[i].lg; want.lb = rows[i].lb;
				want.xr = rows[i].xr; want.xg = rows[i].xg; want.xb = rows[i].xb;
				want.known = 1;
			end else begin
				want = remap_color(rows[i].req);
			end
			send_request(rows[i].req, want);
		end
		in_valid <= 1'b0;
		wait_idle();
		write_reg(CFG_BASE_INTENSITY, 0);
		write_reg(CFG_ALPHA_LEVEL, 0);
		write_reg(CFG_LIT_COLOR, 24'hFFFFFF);
		write_reg(CFG_PIXEL_AREA_COLOR, 24'h000000);
		send_random(130);
		wait_idle();
		write_reg(CFG_BASE_INTENSITY, 256);
		write_reg(CFG_ALPHA_LEVEL, 256);
		write_reg(CFG_LIT_COLOR, 24'h123456);
		write_reg(CFG_PIXEL_AREA_COLOR, 24'hFFFFFF);
		send_random(130);
		wait_idle();
		write_reg(CFG_BASE_INTENSITY, 9'h1FF);
		write_reg(CFG_ALPHA_LEVEL, 9'h1FF);
		write_reg(CFG_UNMAPPED, 24'hABCDEF);
		write_reg(CFG_LIT_COLOR, 24'h808080);
		send_random(100);
		wait_idle();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_BASE_INTENSITY, $urandom_range(0, 511));
			write_reg(CFG_ALPHA_LEVEL, $urandom_range(0, 511));
			write_reg(CFG_LIT_COLOR, $urandom);
			write_reg(CFG_PIXEL_AREA_COLOR, $urandom);
			send_random(50);
			wait_idle();
		end
		sending_done = 1;
	end

	initial begin
		@(posedge sending_done);
		drain_mode = 1;
		if (errors == 0 && pending_colors.size() == 0)
			$display("== PASS ==");
		else begin
			if (pending_colors.size() != 0)
				$error("%0d results never arrived", pending_colors.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/brc_pkg.sv
design/brc_div.sv
design/brc_rebuild.sv
design/brc_blend.sv
design/backlight_color_remap_unit.sv
tb/sv/tb_top.sv
